// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SMSC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define SMSC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ===== hdl/smsc_pkg.sv =====
//------------------------------------------------------------------------------
// smsc_pkg
// Shared types and constants of the straight-move speed controller.
//------------------------------------------------------------------------------
`default_nettype none
package smsc_pkg;
	localparam int GAIN_W = 16;
	localparam int DRV_W  = 8;
	localparam int OUT_W  = 9;
	localparam int IDX_W  = 3;
	localparam int DONE_TOL = 1280;  // 5.0 in Q.8

	typedef enum logic [IDX_W-1:0] {
		REG_PROP  = 3'd0,
		REG_INTEG = 3'd1,
		REG_HEAD  = 3'd2,
		REG_DMIN  = 3'd3,
		REG_DMAX  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic num;
		logic div_start;
		logic vel;
		logic integ;
		logic mpr;
		logic mir;
		logic mpl;
		logic mil;
		logic mc;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic done_hit;
		logic need_div;
		logic div_done;
		logic out_busy;
	} stat_t;
endpackage
`default_nettype wire

// ===== hdl/smsc_div.sv =====
//------------------------------------------------------------------------------
// smsc_div
// Restoring unsigned divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module smsc_div #(
	parameter int VW = 24,
	parameter int NW = 47
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quot
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [VW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [VW:0]   rsh, rnext;
	logic          ge;

	always_comb begin
		rsh   = {rem_q, q_q[NW-1]};
		ge    = rsh >= {1'b0, divisor};
		rnext = ge ? rsh - {1'b0, divisor} : rsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			q_q   <= {q_q[NW-2:0], ge};
			rem_q <= rnext[VW-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule
`default_nettype wire

// ===== hdl/smsc_ctrl.sv =====
//------------------------------------------------------------------------------
// smsc_ctrl
// Sequencer: steps the datapath through profile, optional divide and PI phases.
//------------------------------------------------------------------------------
`default_nettype none
module smsc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire smsc_pkg::stat_t stat,
	output smsc_pkg::cmd_t      cmd
);
	import smsc_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_PREP = 13'b0000000000010,
		ST_NUM  = 13'b0000000000100,
		ST_DIVS = 13'b0000000001000,
		ST_DIV  = 13'b0000000010000,
		ST_VEL  = 13'b0000000100000,
		ST_INT  = 13'b0000001000000,
		ST_MPR  = 13'b0000010000000,
		ST_MIR  = 13'b0000100000000,
		ST_MPL  = 13'b0001000000000,
		ST_MIL  = 13'b0010000000000,
		ST_MC   = 13'b0100000000000,
		ST_FIN  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = stat.done_hit ? ST_FIN : ST_NUM;
			end
			ST_NUM: begin
				cmd.num = 1'b1;
				state_d = stat.need_div ? ST_DIVS : ST_VEL;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_VEL;
			end
			ST_VEL: begin
				cmd.vel = 1'b1;
				state_d = ST_INT;
			end
			ST_INT: begin
				cmd.integ = 1'b1;
				state_d   = ST_MPR;
			end
			ST_MPR: begin
				cmd.mpr = 1'b1;
				state_d = ST_MIR;
			end
			ST_MIR: begin
				cmd.mir = 1'b1;
				state_d = ST_MPL;
			end
			ST_MPL: begin
				cmd.mpl = 1'b1;
				state_d = ST_MIL;
			end
			ST_MIL: begin
				cmd.mil = 1'b1;
				state_d = ST_MC;
			end
			ST_MC: begin
				cmd.mc  = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign in_stall = (state_q != ST_IDLE);
endmodule
`default_nettype wire

// ===== hdl/smsc_dp.sv =====
//------------------------------------------------------------------------------
// smsc_dp
// Datapath: input capture, speed profile, integrators, shared gain multiplier,
// clamps and the output register.
//------------------------------------------------------------------------------
`default_nettype none
module smsc_dp #(
	parameter int VW = 24,
	parameter int IW = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire smsc_pkg::cmd_t                cmd,
	output smsc_pkg::stat_t                    stat,
	input  wire logic [smsc_pkg::GAIN_W-1:0]   prop_gain,
	input  wire logic [smsc_pkg::GAIN_W-1:0]   integ_gain,
	input  wire logic [smsc_pkg::GAIN_W-1:0]   heading_gain,
	input  wire logic [smsc_pkg::DRV_W-1:0]    drive_min,
	input  wire logic [smsc_pkg::DRV_W-1:0]    drive_max,
	input  wire logic                          start_req,
	input  wire logic signed [VW-1:0]          target_distance,
	input  wire logic [VW-2:0]                 cruise_speed,
	input  wire logic signed [VW-1:0]          travelled,
	input  wire logic signed [VW-1:0]          speed_right,
	input  wire logic signed [VW-1:0]          speed_left,
	input  wire logic signed [VW-1:0]          path_right,
	input  wire logic signed [VW-1:0]          path_left,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic signed [smsc_pkg::OUT_W-1:0]  drive_right,
	output logic signed [smsc_pkg::OUT_W-1:0]  drive_left,
	output logic                               done_res
);
	import smsc_pkg::*;

	localparam int NW = 2 * VW - 1;
	localparam int EW = VW + 1;
	localparam int BW = (IW > EW) ? IW : EW;
	localparam int PW = GAIN_W + 1 + BW;
	localparam int FW = PW + 1;
	localparam int SW = BW + 1;
	localparam int LW = 26;

	localparam logic signed [NW:0] VMAX = {{(NW + 2 - VW){1'b0}}, {(VW - 1){1'b1}}};
	localparam logic signed [NW:0] VMIN = {{(NW + 2 - VW){1'b1}}, {(VW - 1){1'b0}}};
	localparam logic signed [SW-1:0] IMAX = {{(SW - IW + 1){1'b0}}, {(IW - 1){1'b1}}};
	localparam logic signed [SW-1:0] IMIN = {{(SW - IW + 1){1'b1}}, {(IW - 1){1'b0}}};
	localparam logic signed [FW-1:0] PMAX = {{(FW - 41){1'b0}}, 1'b1, {40{1'b0}}};
	localparam logic signed [FW-1:0] PMIN = -PMAX;
	localparam logic signed [EW:0]   TOL  = (EW + 1)'(DONE_TOL);

	// captured inputs
	logic signed [VW-1:0] target_q, trav_q, sr_q, sl_q, pr_q, pl_q;
	logic [VW-2:0]        cruise_q;
	// profile
	logic [VW-1:0]        d_q, t_q, dtabs_q;
	logic                 rise_q, fall_q, dtneg_q, sens_q, done_q;
	logic signed [EW-1:0] pdiff_q;
	logic [NW-1:0]        num_q;
	// loop
	logic signed [EW-1:0] err_r_q, err_l_q;
	logic signed [IW-1:0] integ_r_q, integ_l_q;
	logic signed [LW-1:0] lo_q, hi_q;
	logic signed [PW-1:0] prod_q;
	logic signed [FW-1:0] acc_r_q, acc_l_q;
	// output register
	logic                 ovalid_q, odone_q;
	logic signed [OUT_W-1:0] odr_q, odl_q;

	logic                 div_done;
	logic [NW-1:0]        quot;

	function automatic logic signed [FW-1:0] band(input logic signed [FW-1:0] v,
			input logic signed [LW-1:0] lo, input logic signed [LW-1:0] hi);
		logic signed [FW-1:0] l, h;
		l = FW'(lo);
		h = FW'(hi);
		if (v < l)      band = l;
		else if (v > h) band = h;
		else            band = v;
	endfunction

	function automatic logic signed [SW-1:0] integ_add(input logic signed [IW-1:0] a,
			input logic signed [EW-1:0] e);
		logic signed [SW-1:0] s;
		s = SW'(a) + SW'(e);
		if (s > IMAX)      integ_add = IMAX;
		else if (s < IMIN) integ_add = IMIN;
		else               integ_add = s;
	endfunction

	function automatic logic signed [OUT_W-1:0] to_int(input logic signed [FW-1:0] x);
		logic signed [FW-1:0] r;
		r = x + (x[FW-1] ? FW'(65535) : FW'(0));
		to_int = r[24:16];
	endfunction

	// done test and profile branch, from captured inputs
	logic signed [EW-1:0] diff;
	logic [VW-1:0]        d_c, t_c;
	logic signed [EW-1:0] dt_c;
	logic                 rise_c, fall_c;
	always_comb begin
		diff   = EW'(trav_q) - EW'(target_q);
		d_c    = target_q[VW-1] ? VW'(-target_q) : VW'(target_q);
		t_c    = trav_q[VW-1] ? VW'(-trav_q) : VW'(trav_q);
		dt_c   = $signed({1'b0, d_c}) - $signed({1'b0, t_c});
		rise_c = {t_c, 2'b00} < {2'b00, d_c};
		fall_c = !rise_c && ($signed({dt_c, 1'b0}) < $signed({2'b00, d_c}));
	end

	// profile magnitude to signed speed command and errors
	logic [NW-1:0]        mag;
	logic                 mneg;
	logic signed [NW:0]   vs;
	logic signed [VW-1:0] v;
	logic signed [VW:0]   csr;
	logic signed [VW-1:0] cs;
	always_comb begin
		mag  = quot;
		mneg = fall_q && dtneg_q;
		if (!rise_q && !fall_q) begin
			mag  = NW'(cruise_q);
			mneg = 1'b0;
		end else if (d_q == '0) begin
			mag = '0;
		end
		vs = mneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		if (vs > VMAX)      v = VMAX[VW-1:0];
		else if (vs < VMIN) v = VMIN[VW-1:0];
		else                v = vs[VW-1:0];
		csr = sens_q ? (VW + 1)'(v) : -((VW + 1)'(v));
		cs  = (csr[VW] ^ csr[VW-1]) ? {1'b0, {(VW - 1){1'b1}}} : csr[VW-1:0];
	end

	// shared gain multiplier
	logic signed [GAIN_W:0] mul_a;
	logic signed [BW-1:0]   mul_b;
	logic signed [FW-1:0]   psat;
	always_comb begin
		mul_a = $signed({1'b0, prop_gain});
		mul_b = BW'(err_r_q);
		if (cmd.mir) begin
			mul_a = $signed({1'b0, integ_gain});
			mul_b = BW'(integ_r_q);
		end else if (cmd.mpl) begin
			mul_b = BW'(err_l_q);
		end else if (cmd.mil) begin
			mul_a = $signed({1'b0, integ_gain});
			mul_b = BW'(integ_l_q);
		end else if (cmd.mc) begin
			mul_a = $signed({1'b0, heading_gain});
			mul_b = BW'(pdiff_q);
		end
		if (FW'(prod_q) > PMAX)      psat = PMAX;
		else if (FW'(prod_q) < PMIN) psat = PMIN;
		else                         psat = FW'(prod_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q <= target_distance;
			cruise_q <= cruise_speed;
			trav_q   <= travelled;
			sr_q     <= speed_right;
			sl_q     <= speed_left;
			pr_q     <= path_right;
			pl_q     <= path_left;
		end
		if (cmd.prep) begin
			d_q     <= d_c;
			t_q     <= t_c;
			dtabs_q <= dt_c[VW] ? VW'(-dt_c) : VW'(dt_c);
			dtneg_q <= dt_c[VW];
			rise_q  <= rise_c;
			fall_q  <= fall_c;
			sens_q  <= diff[VW];
			done_q  <= stat.done_hit;
			pdiff_q <= EW'(pr_q) - EW'(pl_q);
		end
		if (cmd.num) begin
			if (rise_q) num_q <= NW'(cruise_q * t_q) << 2;
			else        num_q <= NW'(cruise_q * dtabs_q) << 1;
		end
		if (cmd.vel) begin
			err_r_q <= EW'(cs) - EW'(sr_q);
			err_l_q <= EW'(cs) - EW'(sl_q);
			if (sens_q) begin
				lo_q <= $signed({2'b00, drive_min, 16'h0000});
				hi_q <= $signed({2'b00, drive_max, 16'h0000});
			end else begin
				lo_q <= -$signed({2'b00, drive_max, 16'h0000});
				hi_q <= -$signed({2'b00, drive_min, 16'h0000});
			end
		end
		if (cmd.mpr || cmd.mir || cmd.mpl || cmd.mil || cmd.mc)
			prod_q <= mul_a * mul_b;
		if (cmd.mir) acc_r_q <= psat;
		if (cmd.mpl) acc_r_q <= band(acc_r_q + psat, lo_q, hi_q);
		if (cmd.mil) acc_l_q <= psat;
		if (cmd.mc)  acc_l_q <= band(acc_l_q + psat, lo_q, hi_q);
		if (cmd.fin) begin
			if (done_q) begin
				odr_q   <= '0;
				odl_q   <= '0;
				odone_q <= 1'b1;
			end else begin
				// right/left swap
				odr_q   <= to_int(band(acc_l_q + FW'(prod_q), lo_q, hi_q));
				odl_q   <= to_int(band(acc_r_q - FW'(prod_q), lo_q, hi_q));
				odone_q <= 1'b0;
			end
		end
	end

	logic signed [SW-1:0] ir_n, il_n;
	assign ir_n = integ_add(integ_r_q, err_r_q);
	assign il_n = integ_add(integ_l_q, err_l_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_r_q <= '0;
			integ_l_q <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cmd.load && start_req) begin
				integ_r_q <= '0;
				integ_l_q <= '0;
			end else if (cmd.integ) begin
				integ_r_q <= ir_n[IW-1:0];
				integ_l_q <= il_n[IW-1:0];
			end
			if (cmd.fin)         ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
		end
	end

	smsc_div #(.VW(VW), .NW(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_q),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (quot)
	);

	always_comb begin
		stat.done_hit = ($signed({diff[EW-1], diff}) <= TOL) &&
			($signed({diff[EW-1], diff}) >= -TOL);
		stat.need_div = (rise_q || fall_q) && (d_q != '0);
		stat.div_done = div_done;
		stat.out_busy = ovalid_q && out_stall;
	end

	assign out_valid   = ovalid_q;
	assign drive_right = odr_q;
	assign drive_left  = odl_q;
	assign done_res    = odone_q;
endmodule
`default_nettype wire

// ===== hdl/straight_move_speed_controller_unit.sv =====
// Sequence: ticks on the ramps go through the restoring divider, one quotient bit per cycle;
//   ticks on the plateau or with a zero target skip the divider, and done ticks skip the
//   profile and PI steps.
// Throughput: one tick at a time; the next tick is taken once the result is in the
//   output register, which may still be waiting for its transfer.
// Reset: arst_n low clears integrators, sequencer and output valid, and loads gain and
//   drive band registers with their defaults.
//------------------------------------------------------------------------------
// straight_move_speed_controller_unit
// Trapezoidal speed profile with per-wheel PI loops, heading correction and
// directional drive clamps.
//------------------------------------------------------------------------------
`default_nettype none
module straight_move_speed_controller_unit #(
	parameter int VALUE_WIDTH = 24,
	parameter int INTEG_WIDTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [smsc_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [smsc_pkg::GAIN_W-1:0]      cfg_data,
	// tick input
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             start_req,
	input  wire logic signed [VALUE_WIDTH-1:0]    target_distance,
	input  wire logic [VALUE_WIDTH-2:0]           cruise_speed,
	input  wire logic signed [VALUE_WIDTH-1:0]    travelled,
	input  wire logic signed [VALUE_WIDTH-1:0]    speed_right,
	input  wire logic signed [VALUE_WIDTH-1:0]    speed_left,
	input  wire logic signed [VALUE_WIDTH-1:0]    path_right,
	input  wire logic signed [VALUE_WIDTH-1:0]    path_left,
	// result output
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [smsc_pkg::OUT_W-1:0]     drive_right,
	output logic signed [smsc_pkg::OUT_W-1:0]     drive_left,
	output logic                                  done_res
);
	import smsc_pkg::*;

	`include "assert_macros.svh"

	logic [GAIN_W-1:0] prop_q, integ_q, head_q;
	logic [DRV_W-1:0]  dmin_q, dmax_q;
	cmd_t              cmd;
	stat_t             stat;

	// config is always accepted; indexes past the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= GAIN_W'(256);
			integ_q <= '0;
			head_q  <= '0;
			dmin_q  <= '0;
			dmax_q  <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROP:  prop_q  <= cfg_data;
				REG_INTEG: integ_q <= cfg_data;
				REG_HEAD:  head_q  <= cfg_data;
				REG_DMIN:  dmin_q  <= cfg_data[DRV_W-1:0];
				REG_DMAX:  dmax_q  <= cfg_data[DRV_W-1:0];
				default:   ;
			endcase
		end
	end

	// sequencer: one tick in flight, input held off until the tick finishes
	smsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: profile, divider, PI loops, clamps, output register
	smsc_dp #(.VW(VALUE_WIDTH), .IW(INTEG_WIDTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.prop_gain       (prop_q),
		.integ_gain      (integ_q),
		.heading_gain    (head_q),
		.drive_min       (dmin_q),
		.drive_max       (dmax_q),
		.start_req       (start_req),
		.target_distance (target_distance),
		.cruise_speed    (cruise_speed),
		.travelled       (travelled),
		.speed_right     (speed_right),
		.speed_left      (speed_left),
		.path_right      (path_right),
		.path_left       (path_left),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.drive_right     (drive_right),
		.drive_left      (drive_left),
		.done_res        (done_res)
	);

	// a transfer in makes the block busy in the next cycle
	`SMSC_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)
	// a new result only appears while a tick is being worked
	`SMSC_ASSERT_IMP(a_res_from_tick, clk, arst_n, $rose(out_valid), $past(in_stall))
	// done forces zero drive
	`SMSC_ASSERT_IMP(a_done_zero, clk, arst_n, out_valid && done_res,
		drive_right == '0 && drive_left == '0)
endmodule
`default_nettype wire
